FILE: hw/rtl/bbpe_pkg.sv
// Shared constants, types and codes of the bicubic Bezier patch evaluator.
package bbpe_pkg;

   localparam int COORD_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int PARAM_W    = FRAC_W + 1;
   localparam int BASIS_W    = PARAM_W + 2;
   localparam int PROD_W     = BASIS_W + 1 + COORD_W;
   localparam int N_PTS      = 16;
   localparam int IDX_W      = 4;
   localparam int HALF_IDX_W = IDX_W / 2;
   localparam int ACC_W      = PROD_W + IDX_W;
   localparam int SHF_W      = ACC_W + 1 - FRAC_W;
   localparam int MULT_W     = 2 * BASIS_W;

   localparam int STEPS_PER_PARAM = 7;
   localparam int BASIS_ISSUES    = 2 * STEPS_PER_PARAM;
   localparam int DRAIN_CYCLES    = 2;

   localparam logic [IDX_W-1:0] BASIS_LAST  = IDX_W'(BASIS_ISSUES);
   localparam logic [IDX_W-1:0] PARAM_SPLIT = IDX_W'(STEPS_PER_PARAM);
   localparam logic [IDX_W-1:0] WEIGHT_LAST = IDX_W'(N_PTS - 1);
   localparam logic [IDX_W-1:0] DRAIN_LAST  = IDX_W'(DRAIN_CYCLES - 1);

   localparam logic [PARAM_W-1:0] PARAM_ONE  = PARAM_W'(1) << FRAC_W;
   localparam logic [MULT_W:0]    RMUL_HALF  = (MULT_W + 1)'(1) << (FRAC_W - 1);
   localparam logic [ACC_W:0]     ACC_HALF   = (ACC_W + 1)'(1) << (FRAC_W - 1);

   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

   localparam int REQ_OFF_ROW = 0;
   localparam int REQ_OFF_COL = REQ_OFF_ROW + HALF_IDX_W;
   localparam int REQ_OFF_X   = REQ_OFF_COL + HALF_IDX_W;
   localparam int REQ_OFF_Y   = REQ_OFF_X + COORD_W;
   localparam int REQ_OFF_Z   = REQ_OFF_Y + COORD_W;
   localparam int REQ_OFF_U   = REQ_OFF_Z + COORD_W;
   localparam int REQ_OFF_V   = REQ_OFF_U + PARAM_W;
   localparam int REQ_RAW_W   = REQ_OFF_V + PARAM_W;
   localparam int REQ_DATA_W  = ((REQ_RAW_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((3 * COORD_W + 7) / 8) * 8;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   typedef enum logic [2:0] {
      STEP_TT,
      STEP_TS,
      STEP_SS,
      STEP_B3,
      STEP_B2,
      STEP_B1,
      STEP_B0
   } step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASIS,
      ST_WEIGHT,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             valid;
      logic [IDX_W-1:0] idx;
   } mac_ctl_type;

endpackage

FILE: hw/rtl/bbpe_rmul.sv
// Shared rounding multiplier: registered (a*b + half) >> FRAC_W.
module bbpe_rmul
   import bbpe_pkg::*;
(
   input  logic               clock,
   input  logic [BASIS_W-1:0] op_a,
   input  logic [BASIS_W-1:0] op_b,
   output logic [BASIS_W-1:0] res
);

   logic [MULT_W-1:0] prod;
   logic [MULT_W:0]   full;
   logic [BASIS_W-1:0] res_ff;

   assign prod = op_a * op_b;
   assign full = {1'b0, prod} + RMUL_HALF;
   assign res  = res_ff;

   always_ff @(posedge clock) begin
      res_ff <= full[FRAC_W +: BASIS_W];
   end

endmodule

FILE: hw/rtl/bbpe_lane.sv
// One coordinate lane: weighted multiply-accumulate, rounding and saturation.
module bbpe_lane
   import bbpe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  mac_ctl_type               mac_ctl,
   input  logic [BASIS_W-1:0]        weight,
   input  logic signed [COORD_W-1:0] point,
   output logic [COORD_W-1:0]        value,
   output logic                      sat
);

   logic signed [PROD_W-1:0]  prod_ff;
   logic                      pv_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [BASIS_W:0]   wsg;
   logic [ACC_W:0]            rnd;
   logic [SHF_W-1:0]          shifted;
   logic [SHF_W-COORD_W:0]    hi;
   logic                      fits;

   assign wsg = $signed({1'b0, weight});

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctl.clear) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= wsg * point;
      acc_ff  <= acc_in;
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= mac_ctl.valid;
      end
   end

   assign rnd     = {acc_ff[ACC_W-1], acc_ff} + ACC_HALF;
   assign shifted = rnd[ACC_W:FRAC_W];
   assign hi      = shifted[SHF_W-1:COORD_W-1];
   assign fits    = (&hi) || (~|hi);
   assign sat     = !fits;

   always_comb begin
      if (fits) begin
         value = shifted[COORD_W-1:0];
      end else if (shifted[SHF_W-1]) begin
         value = COORD_MIN;
      end else begin
         value = COORD_MAX;
      end
   end

endmodule

FILE: hw/rtl/bbpe_seq.sv
// Sequencer: basis products, then weight products for each control point.
module bbpe_seq
   import bbpe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PARAM_W-1:0] u_raw,
   input  logic [PARAM_W-1:0] v_raw,
   input  logic               out_free,
   input  logic [BASIS_W-1:0] rmul_res,
   output logic [BASIS_W-1:0] rmul_a,
   output logic [BASIS_W-1:0] rmul_b,
   output logic               ready,
   output logic               done,
   output mac_ctl_type        mac_ctl
);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [PARAM_W-1:0] u_ff, v_ff;
   logic [BASIS_W-1:0] tt_ff, ts_ff, ss_ff;
   logic [BASIS_W-1:0] bu_ff [4];
   logic [BASIS_W-1:0] bv_ff [4];
   logic               cap_valid_ff, cap_valid_in;
   logic               cap_sel_ff, cap_sel_in;
   step_type           cap_step_ff, cap_step_in;
   logic               wv_ff, wv_in;
   logic [IDX_W-1:0]   kd_ff;
   logic               clear;
   logic               sel;
   logic [IDX_W-1:0]   step_raw;
   logic [PARAM_W-1:0] t_sel, s_sel;
   logic [BASIS_W-1:0] t_ext, s_ext;
   logic [BASIS_W-1:0] res_x3;
   logic [BASIS_W-1:0] cap_val;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_BASIS;
         ST_BASIS:  if (cnt_ff == BASIS_LAST) state_in = ST_WEIGHT;
         ST_WEIGHT: if (cnt_ff == WEIGHT_LAST) state_in = ST_DRAIN;
         ST_DRAIN:  if (cnt_ff == DRAIN_LAST) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + IDX_W'(1);
   end

   assign sel      = (cnt_ff >= PARAM_SPLIT);
   assign step_raw = sel ? (cnt_ff - PARAM_SPLIT) : cnt_ff;
   assign t_sel    = sel ? v_ff : u_ff;
   assign s_sel    = PARAM_ONE - t_sel;
   assign t_ext    = BASIS_W'(t_sel);
   assign s_ext    = BASIS_W'(s_sel);

   // outputs
   always_comb begin
      ready        = (state_ff == ST_IDLE);
      done         = (state_ff == ST_FINISH) && out_free;
      clear        = (state_ff == ST_BASIS) && (cnt_ff == BASIS_LAST);
      wv_in        = (state_ff == ST_WEIGHT);
      cap_valid_in = (state_ff == ST_BASIS) && (cnt_ff != BASIS_LAST);
      cap_sel_in   = sel;
      cap_step_in  = step_type'(step_raw[2:0]);
      rmul_a       = '0;
      rmul_b       = '0;
      case (state_ff)
         ST_BASIS: begin
            case (cap_step_in)
               STEP_TT: begin rmul_a = t_ext; rmul_b = t_ext; end
               STEP_TS: begin rmul_a = t_ext; rmul_b = s_ext; end
               STEP_SS: begin rmul_a = s_ext; rmul_b = s_ext; end
               STEP_B3: begin rmul_a = tt_ff; rmul_b = t_ext; end
               STEP_B2: begin rmul_a = tt_ff; rmul_b = s_ext; end
               STEP_B1: begin rmul_a = ts_ff; rmul_b = s_ext; end
               STEP_B0: begin rmul_a = ss_ff; rmul_b = s_ext; end
               default: begin rmul_a = '0; rmul_b = '0; end
            endcase
         end
         ST_WEIGHT: begin
            rmul_a = bu_ff[cnt_ff[IDX_W-1:HALF_IDX_W]];
            rmul_b = bv_ff[cnt_ff[HALF_IDX_W-1:0]];
         end
         default: begin
            rmul_a = '0;
            rmul_b = '0;
         end
      endcase
      mac_ctl.clear = clear;
      mac_ctl.valid = wv_ff;
      mac_ctl.idx   = kd_ff;
   end

   assign res_x3  = (rmul_res << 1) + rmul_res;
   assign cap_val = (cap_step_ff == STEP_B2 || cap_step_ff == STEP_B1) ? res_x3 : rmul_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cap_valid_ff <= 1'b0;
         wv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cap_valid_ff <= cap_valid_in;
         wv_ff        <= wv_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_sel_ff  <= cap_sel_in;
      cap_step_ff <= cap_step_in;
      kd_ff       <= cnt_ff;
      if (start && ready) begin
         u_ff <= (u_raw > PARAM_ONE) ? PARAM_ONE : u_raw;
         v_ff <= (v_raw > PARAM_ONE) ? PARAM_ONE : v_raw;
      end
      if (cap_valid_ff) begin
         case (cap_step_ff)
            STEP_TT: tt_ff <= rmul_res;
            STEP_TS: ts_ff <= rmul_res;
            STEP_SS: ss_ff <= rmul_res;
            STEP_B3: if (cap_sel_ff) bv_ff[3] <= cap_val; else bu_ff[3] <= cap_val;
            STEP_B2: if (cap_sel_ff) bv_ff[2] <= cap_val; else bu_ff[2] <= cap_val;
            STEP_B1: if (cap_sel_ff) bv_ff[1] <= cap_val; else bu_ff[1] <= cap_val;
            STEP_B0: if (cap_sel_ff) bv_ff[0] <= cap_val; else bu_ff[0] <= cap_val;
            default: tt_ff <= tt_ff;
         endcase
      end
   end

endmodule

FILE: hw/rtl/bicubic_bezier_patch_eval_top.sv
// Top level of the bicubic Bezier patch evaluator.
// A write word stores one control point. An evaluate word passes through these
// steps from acceptance to its result: one shared rounding multiplier forms
// the four Bernstein weights for u and for v; the same multiplier then forms
// one point weight per control point while three lanes multiply-accumulate
// x, y and z; the pipeline drains; and the sums are rounded and saturated
// into the output register. req_tready is low during an evaluation; a
// finished result waiting on rsp_tready does not block write words, but the
// next evaluation holds in its final state until the output register is
// free.
module bicubic_bezier_patch_eval_top
   import bbpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // row, col, pos_x, pos_y, pos_z, u_param, v_param, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x, out_y, out_z
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // saturated
   output logic                  rsp_tuser
);

   logic                      req_accept;
   logic                      wr_en;
   logic                      start;
   logic [IDX_W-1:0]          wr_idx;
   logic [COORD_W-1:0]        ctrl_x_ff [N_PTS];
   logic [COORD_W-1:0]        ctrl_y_ff [N_PTS];
   logic [COORD_W-1:0]        ctrl_z_ff [N_PTS];
   logic [BASIS_W-1:0]        rmul_a, rmul_b, rmul_res;
   logic                      done;
   logic                      out_free;
   mac_ctl_type               mac_ctl;
   logic [COORD_W-1:0]        val_x, val_y, val_z;
   logic                      sat_x, sat_y, sat_z;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]        out_x_ff, out_y_ff, out_z_ff;
   logic                      sat_ff;

   assign req_accept = req_tvalid && req_tready;
   assign wr_en      = req_accept && (req_tuser == MODE_WRITE);
   assign start      = req_accept && (req_tuser == MODE_EVAL);
   assign wr_idx     = {req_tdata[REQ_OFF_ROW +: HALF_IDX_W],
                        req_tdata[REQ_OFF_COL +: HALF_IDX_W]};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N_PTS; k++) begin
            ctrl_x_ff[k] <= '0;
            ctrl_y_ff[k] <= '0;
            ctrl_z_ff[k] <= '0;
         end
      end else if (wr_en) begin
         ctrl_x_ff[wr_idx] <= req_tdata[REQ_OFF_X +: COORD_W];
         ctrl_y_ff[wr_idx] <= req_tdata[REQ_OFF_Y +: COORD_W];
         ctrl_z_ff[wr_idx] <= req_tdata[REQ_OFF_Z +: COORD_W];
      end
   end

   bbpe_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .u_raw    (req_tdata[REQ_OFF_U +: PARAM_W]),
      .v_raw    (req_tdata[REQ_OFF_V +: PARAM_W]),
      .out_free (out_free),
      .rmul_res (rmul_res),
      .rmul_a   (rmul_a),
      .rmul_b   (rmul_b),
      .ready    (req_tready),
      .done     (done),
      .mac_ctl  (mac_ctl)
   );

   bbpe_rmul u_rmul (
      .clock (clock),
      .op_a  (rmul_a),
      .op_b  (rmul_b),
      .res   (rmul_res)
   );

   bbpe_lane u_lane_x (
      .clock   (clock),
      .reset   (reset),
      .mac_ctl (mac_ctl),
      .weight  (rmul_res),
      .point   ($signed(ctrl_x_ff[mac_ctl.idx])),
      .value   (val_x),
      .sat     (sat_x)
   );

   bbpe_lane u_lane_y (
      .clock   (clock),
      .reset   (reset),
      .mac_ctl (mac_ctl),
      .weight  (rmul_res),
      .point   ($signed(ctrl_y_ff[mac_ctl.idx])),
      .value   (val_y),
      .sat     (sat_y)
   );

   bbpe_lane u_lane_z (
      .clock   (clock),
      .reset   (reset),
      .mac_ctl (mac_ctl),
      .weight  (rmul_res),
      .point   ($signed(ctrl_z_ff[mac_ctl.idx])),
      .value   (val_z),
      .sat     (sat_z)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done) begin
         out_x_ff <= val_x;
         out_y_ff <= val_y;
         out_z_ff <= val_z;
         sat_ff   <= sat_x || sat_y || sat_z;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_z_ff, out_y_ff, out_x_ff});
   assign rsp_tuser  = sat_ff;

endmodule

FILE: hw/rtl/bbpe_checker.sv
// Port-level checks of the patch evaluator, bound to the top level.
module bbpe_checker
   import bbpe_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic [COORD_W-1:0] cx, cy, cz;

   assign cx = rsp_tdata[0 +: COORD_W];
   assign cy = rsp_tdata[COORD_W +: COORD_W];
   assign cz = rsp_tdata[2 * COORD_W +: COORD_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_EVAL) |=> !req_tready)
      else $error("ready stayed high after an evaluate word");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_WRITE) |=> !$rose(rsp_tvalid))
      else $error("write word produced a result");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result appeared while still busy");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (cx == COORD_MAX) || (cx == COORD_MIN) || (cy == COORD_MAX) ||
         (cy == COORD_MIN) || (cz == COORD_MAX) || (cz == COORD_MIN))
      else $error("saturation flag without a clamped coordinate");

endmodule

bind bicubic_bezier_patch_eval_top bbpe_checker u_bbpe_checker (.*);

FILE: sim/bbpe_patch_checker.sv
// Checker for the Bezier patch evaluator: mirrors the control grid, predicts surface points.
module bbpe_patch_checker
   import bbpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   output int                    points_in_flight,
   output int                    mismatches
);

   localparam int SUM_W = 80;
   localparam logic signed [SUM_W-1:0] LIM_HI = (80'sd1 <<< (COORD_W - 1)) - 80'sd1;
   localparam logic signed [SUM_W-1:0] LIM_LO = -(80'sd1 <<< (COORD_W - 1));
   localparam logic signed [SUM_W-1:0] SUM_HALF = 80'sd1 <<< (FRAC_W - 1);

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               sat;
   } surface_point_type;

   typedef logic [3:0][31:0] bernstein_type;

   logic signed [COORD_W-1:0] grid [3][N_PTS];
   surface_point_type         surface_q [$];

   function automatic logic [63:0] rnd_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
   endfunction

   function automatic bernstein_type bernstein(input logic [PARAM_W-1:0] p);
      logic [63:0]   t;
      logic [63:0]   s;
      bernstein_type b;
      t = (p > PARAM_ONE) ? 64'(PARAM_ONE) : 64'(p);
      s = 64'(PARAM_ONE) - t;
      b[0] = 32'(rnd_mul(rnd_mul(s, s), s));
      b[1] = 32'(64'd3 * rnd_mul(rnd_mul(t, s), s));
      b[2] = 32'(64'd3 * rnd_mul(rnd_mul(t, t), s));
      b[3] = 32'(rnd_mul(rnd_mul(t, t), t));
      return b;
   endfunction

   function automatic surface_point_type patch_point(input logic [PARAM_W-1:0] u,
                                                     input logic [PARAM_W-1:0] v);
      bernstein_type            bu;
      bernstein_type            bv;
      logic signed [SUM_W-1:0]  acc [3];
      logic signed [SUM_W-1:0]  wt;
      logic signed [SUM_W-1:0]  pv;
      logic signed [SUM_W-1:0]  r;
      logic [COORD_W-1:0]       coord [3];
      surface_point_type        pt;
      bu = bernstein(u);
      bv = bernstein(v);
      pt.sat = 1'b0;
      for (int l = 0; l < 3; l++) acc[l] = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            wt = SUM_W'(rnd_mul(64'(bu[i]), 64'(bv[j])));
            for (int l = 0; l < 3; l++) begin
               pv = grid[l][i*4 + j];
               acc[l] = acc[l] + wt * pv;
            end
         end
      end
      for (int l = 0; l < 3; l++) begin
         r = (acc[l] + SUM_HALF) >>> FRAC_W;
         if (r > LIM_HI) begin
            coord[l] = COORD_MAX;
            pt.sat   = 1'b1;
         end else if (r < LIM_LO) begin
            coord[l] = COORD_MIN;
            pt.sat   = 1'b1;
         end else begin
            coord[l] = r[COORD_W-1:0];
         end
      end
      pt.x = coord[0];
      pt.y = coord[1];
      pt.z = coord[2];
      return pt;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch at %0t: %s, expected %h, got %h", $time, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      surface_point_type got;
      surface_point_type want;
      logic [IDX_W-1:0]  idx;
      if (reset) begin
         for (int k = 0; k < N_PTS; k++) begin
            for (int l = 0; l < 3; l++) grid[l][k] = '0;
         end
         surface_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.x   = rsp_tdata[0 +: COORD_W];
            got.y   = rsp_tdata[COORD_W +: COORD_W];
            got.z   = rsp_tdata[2*COORD_W +: COORD_W];
            got.sat = rsp_tuser;
            if (surface_q.size() == 0) begin
               report_mismatch("result word with none expected", '0, 64'(got.x));
            end else begin
               want = surface_q.pop_front();
               if (got.x !== want.x) report_mismatch("out_x", 64'(want.x), 64'(got.x));
               if (got.y !== want.y) report_mismatch("out_y", 64'(want.y), 64'(got.y));
               if (got.z !== want.z) report_mismatch("out_z", 64'(want.z), 64'(got.z));
               if (got.sat !== want.sat)
                  report_mismatch("saturated", 64'(want.sat), 64'(got.sat));
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == MODE_WRITE) begin
               idx = {req_tdata[REQ_OFF_ROW +: HALF_IDX_W], req_tdata[REQ_OFF_COL +: HALF_IDX_W]};
               grid[0][idx] = req_tdata[REQ_OFF_X +: COORD_W];
               grid[1][idx] = req_tdata[REQ_OFF_Y +: COORD_W];
               grid[2][idx] = req_tdata[REQ_OFF_Z +: COORD_W];
            end else begin
               surface_q.insert(surface_q.size(),
                                patch_point(req_tdata[REQ_OFF_U +: PARAM_W],
                                            req_tdata[REQ_OFF_V +: PARAM_W]));
            end
         end
      end
      points_in_flight <= surface_q.size();
   end

endmodule

FILE: sim/tb_bicubic_bezier_patch_eval_top.sv
// Testbench top of the Bezier patch evaluator: drives control point and evaluate words.
module tb_bicubic_bezier_patch_eval_top;
   import bbpe_pkg::*;

   localparam int WORD_TARGET   = 500;
   localparam int CALM_FROM     = 430;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [PARAM_W-1:0] PARAM_TOP = '1;

   typedef enum int {
      FILL_RANDOM,
      FILL_MAX,
      FILL_MIN,
      FILL_SMALL,
      FILL_EDGE
   } fill_style_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = MODE_WRITE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   int                    points_in_flight;
   int                    mismatches;
   int                    words_sent = 0;
   int                    gap_pct    = 0;
   int                    hold_pct   = 0;
   logic                  calm       = 1'b0;
   int                    pct_choice [3] = '{0, 15, 40};

   bicubic_bezier_patch_eval_top uut (.*);

   bbpe_patch_checker watch (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("bicubic_bezier_patch_eval_top verification failed");
      $finish;
   end

   task automatic send_word(input logic mode, input logic [HALF_IDX_W-1:0] row,
                            input logic [HALF_IDX_W-1:0] col, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                            input logic [PARAM_W-1:0] u, input logic [PARAM_W-1:0] v);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[REQ_OFF_ROW +: HALF_IDX_W] = row;
      d[REQ_OFF_COL +: HALF_IDX_W] = col;
      d[REQ_OFF_X +: COORD_W]      = x;
      d[REQ_OFF_Y +: COORD_W]      = y;
      d[REQ_OFF_Z +: COORD_W]      = z;
      d[REQ_OFF_U +: PARAM_W]      = u;
      d[REQ_OFF_V +: PARAM_W]      = v;
      req_tdata  <= d;
      req_tuser  <= mode;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic put_point(input logic [HALF_IDX_W-1:0] row, input logic [HALF_IDX_W-1:0] col,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z);
      send_word(MODE_WRITE, row, col, x, y, z, PARAM_W'($urandom), PARAM_W'($urandom));
   endtask

   task automatic eval_at(input logic [PARAM_W-1:0] u, input logic [PARAM_W-1:0] v);
      send_word(MODE_EVAL, HALF_IDX_W'($urandom), HALF_IDX_W'($urandom), $urandom, $urandom,
                $urandom, u, v);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(input fill_style_type style);
      logic signed [20:0] near_zero;
      near_zero = 21'($urandom);
      case (style)
         FILL_MAX:   return COORD_MAX;
         FILL_MIN:   return COORD_MIN;
         FILL_SMALL: return COORD_W'(near_zero);
         FILL_EDGE:  return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         default:    return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [PARAM_W-1:0] pick_param();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return PARAM_ONE;
         2:       return PARAM_W'($urandom_range(PARAM_ONE + 1, PARAM_TOP));
         default: return PARAM_W'($urandom_range(0, PARAM_ONE));
      endcase
   endfunction

   task automatic fill_grid(input fill_style_type style);
      for (int k = 0; k < N_PTS; k++) begin
         put_point(HALF_IDX_W'(k >> HALF_IDX_W), HALF_IDX_W'(k), pick_coord(style),
                   pick_coord(style), pick_coord(style));
      end
   endtask

   task automatic drain_points();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (points_in_flight != 0);
   endtask

   // randomly withhold rsp_tready in short bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 99) < hold_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      fill_style_type style;
      logic           mid_drained;
      mid_drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      eval_at('0, '0);
      fill_grid(FILL_MAX);
      eval_at('0, '0);
      eval_at(PARAM_ONE, PARAM_ONE);
      eval_at(PARAM_ONE >> 1, PARAM_ONE >> 1);
      eval_at(PARAM_TOP, '0);
      eval_at(PARAM_W'(21845), PARAM_W'(43690));
      drain_points();

      while (words_sent < WORD_TARGET) begin
         if (!mid_drained && words_sent >= WORD_TARGET / 2) begin
            drain_points();
            mid_drained = 1'b1;
         end
         calm     = (words_sent >= CALM_FROM);
         gap_pct  = pct_choice[$urandom_range(0, 2)];
         hold_pct = pct_choice[$urandom_range(0, 2)];
         if ($urandom_range(0, 9) < 7) begin
            style = fill_style_type'($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0) begin
               fill_grid(style);
            end else begin
               repeat ($urandom_range(1, 6))
                  put_point(HALF_IDX_W'($urandom), HALF_IDX_W'($urandom), pick_coord(style),
                            pick_coord(style), pick_coord(style));
            end
            repeat ($urandom_range(1, 4)) eval_at(pick_param(), pick_param());
         end else begin
            send_word(1'($urandom), HALF_IDX_W'($urandom), HALF_IDX_W'($urandom), $urandom,
                      $urandom, $urandom, PARAM_W'($urandom), PARAM_W'($urandom));
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (points_in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("bicubic_bezier_patch_eval_top verification clean");
      end else begin
         $display("bicubic_bezier_patch_eval_top verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bbpe_pkg.sv
hw/rtl/bbpe_rmul.sv
hw/rtl/bbpe_lane.sv
hw/rtl/bbpe_seq.sv
hw/rtl/bicubic_bezier_patch_eval_top.sv
hw/rtl/bbpe_checker.sv
sim/bbpe_patch_checker.sv
sim/tb_bicubic_bezier_patch_eval_top.sv
